/* hw/rtl/bpo_pkg.sv */
// Shared types for the box pair overlap ratio and merge block.
// No dependencies; compiled first.
package bpo_pkg;

    // How the final overlap ratio is formed at the output stage.
    typedef enum logic [1:0] {
        RSEL_DIV  = 2'd0,   // quotient from the divider chain
        RSEL_ZERO = 2'd1,   // reference area zero or negative
        RSEL_ONE  = 2'd2    // overlap covers the whole reference box
    } t_ratio_sel;

endpackage

/* hw/rtl/bpo_req_if.sv */
// Request channel: a reference box and an other box, valid/ready handshake.
// Depends on nothing; compiled after bpo_pkg.
interface bpo_req_if #(
    parameter int COORD_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] ref_left;
    logic signed [COORD_BITS-1:0] ref_top;
    logic signed [COORD_BITS-1:0] ref_right;
    logic signed [COORD_BITS-1:0] ref_bottom;
    logic signed [COORD_BITS-1:0] oth_left;
    logic signed [COORD_BITS-1:0] oth_top;
    logic signed [COORD_BITS-1:0] oth_right;
    logic signed [COORD_BITS-1:0] oth_bottom;

    modport source (
        output valid, ref_left, ref_top, ref_right, ref_bottom,
               oth_left, oth_top, oth_right, oth_bottom,
        input  ready
    );
    modport sink (
        input  valid, ref_left, ref_top, ref_right, ref_bottom,
               oth_left, oth_top, oth_right, oth_bottom,
        output ready
    );
endinterface

/* hw/rtl/bpo_rsp_if.sv */
// Response channel: touch flag, overlap ratio and merged box.
// Depends on nothing; compiled after bpo_pkg.
interface bpo_rsp_if #(
    parameter int COORD_BITS      = 16,
    parameter int RATIO_FRAC_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic                         boxes_touch;
    logic [RATIO_FRAC_BITS:0]     overlap_ratio;
    logic signed [COORD_BITS-1:0] union_left;
    logic signed [COORD_BITS-1:0] union_top;
    logic signed [COORD_BITS-1:0] union_right;
    logic signed [COORD_BITS-1:0] union_bottom;

    modport source (
        output valid, boxes_touch, overlap_ratio,
               union_left, union_top, union_right, union_bottom,
        input  ready
    );
    modport sink (
        input  valid, boxes_touch, overlap_ratio,
               union_left, union_top, union_right, union_bottom,
        output ready
    );
endinterface

/* hw/rtl/bpo_geom.sv */
// Edge stage: touch test, merged box, clamped overlap extents, reference extents.
// Standalone; no package use.
module bpo_geom #(
    parameter int COORD_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic signed [COORD_BITS-1:0] i_rl,
    input  logic signed [COORD_BITS-1:0] i_rt,
    input  logic signed [COORD_BITS-1:0] i_rr,
    input  logic signed [COORD_BITS-1:0] i_rb,
    input  logic signed [COORD_BITS-1:0] i_ol,
    input  logic signed [COORD_BITS-1:0] i_ot,
    input  logic signed [COORD_BITS-1:0] i_or,
    input  logic signed [COORD_BITS-1:0] i_ob,
    output logic                         o_touch,
    output logic signed [COORD_BITS-1:0] o_ul,
    output logic signed [COORD_BITS-1:0] o_ut,
    output logic signed [COORD_BITS-1:0] o_ur,
    output logic signed [COORD_BITS-1:0] o_ub,
    output logic [COORD_BITS-1:0]        o_w,
    output logic [COORD_BITS-1:0]        o_h,
    output logic signed [COORD_BITS:0]   o_dx,
    output logic signed [COORD_BITS:0]   o_dy
);
    localparam int DW = COORD_BITS + 1;

    logic signed [COORD_BITS-1:0] w_min_r, w_max_l, w_min_b, w_max_t;
    logic signed [DW-1:0]         w_iw, w_ih;

    always_comb begin
        w_min_r = (i_rr < i_or) ? i_rr : i_or;
        w_max_l = (i_rl > i_ol) ? i_rl : i_ol;
        w_min_b = (i_rb < i_ob) ? i_rb : i_ob;
        w_max_t = (i_rt > i_ot) ? i_rt : i_ot;
        w_iw    = {w_min_r[COORD_BITS-1], w_min_r} - {w_max_l[COORD_BITS-1], w_max_l};
        w_ih    = {w_min_b[COORD_BITS-1], w_min_b} - {w_max_t[COORD_BITS-1], w_max_t};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_touch <= (i_rr >= i_ol) && (i_rl <= i_or) && (i_rb >= i_ot) && (i_rt <= i_ob);
            o_ul    <= (i_rl < i_ol) ? i_rl : i_ol;
            o_ut    <= (i_rt < i_ot) ? i_rt : i_ot;
            o_ur    <= (i_rr > i_or) ? i_rr : i_or;
            o_ub    <= (i_rb > i_ob) ? i_rb : i_ob;
            // negative extent clamps to zero; positive fits COORD_BITS unsigned
            o_w     <= w_iw[DW-1] ? '0 : w_iw[COORD_BITS-1:0];
            o_h     <= w_ih[DW-1] ? '0 : w_ih[COORD_BITS-1:0];
            o_dx    <= {i_rr[COORD_BITS-1], i_rr} - {i_rl[COORD_BITS-1], i_rl};
            o_dy    <= {i_rb[COORD_BITS-1], i_rb} - {i_rt[COORD_BITS-1], i_rt};
        end
    end
endmodule

/* hw/rtl/bpo_area.sv */
// Area stages: two multipliers, then classification and divider setup.
// Uses bpo_pkg for the ratio select code.
module bpo_area #(
    parameter int COORD_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_en_mul,
    input  logic                          i_en_cls,
    input  logic [COORD_BITS-1:0]         i_w,
    input  logic [COORD_BITS-1:0]         i_h,
    input  logic signed [COORD_BITS:0]    i_dx,
    input  logic signed [COORD_BITS:0]    i_dy,
    output logic [2*COORD_BITS-1:0]       o_rem,
    output logic [2*COORD_BITS-1:0]       o_den,
    output bpo_pkg::t_ratio_sel           o_sel
);
    import bpo_pkg::*;

    localparam int AW = 2 * COORD_BITS;
    localparam int PW = 2 * (COORD_BITS + 1);

    logic [AW-1:0]        r_ov;
    logic signed [PW-1:0] r_ra;
    logic                 w_ra_nonpos;

    always_ff @(posedge i_clk) begin
        if (i_en_mul) begin
            r_ov <= i_w * i_h;
            r_ra <= i_dx * i_dy;
        end
    end

    // a positive reference area always fits AW bits unsigned
    assign w_ra_nonpos = r_ra[PW-1] || (r_ra == '0);

    always_ff @(posedge i_clk) begin
        if (i_en_cls) begin
            o_rem <= r_ov;
            o_den <= r_ra[AW-1:0];
            if (w_ra_nonpos) begin
                o_sel <= RSEL_ZERO;
            end else if (r_ov >= r_ra[AW-1:0]) begin
                o_sel <= RSEL_ONE;
            end else begin
                o_sel <= RSEL_DIV;
            end
        end
    end
endmodule

/* hw/rtl/bpo_div_step.sv */
// One restoring division step: one quotient bit per register stage.
// Standalone; no package use.
module bpo_div_step #(
    parameter int AREA_BITS = 32,
    parameter int QUO_BITS  = 16
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [AREA_BITS-1:0] i_rem,
    input  logic [AREA_BITS-1:0] i_den,
    input  logic [QUO_BITS-1:0]  i_quo,
    output logic [AREA_BITS-1:0] o_rem,
    output logic [AREA_BITS-1:0] o_den,
    output logic [QUO_BITS-1:0]  o_quo
);
    logic [AREA_BITS:0] w_sh, w_diff;
    logic               w_ge;

    always_comb begin
        w_sh   = {i_rem, 1'b0};
        w_ge   = w_sh >= {1'b0, i_den};
        w_diff = w_sh - {1'b0, i_den};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem <= w_ge ? w_diff[AREA_BITS-1:0] : w_sh[AREA_BITS-1:0];
            o_den <= i_den;
            o_quo <= {i_quo[QUO_BITS-2:0], w_ge};
        end
    end
endmodule

/* hw/rtl/box_pair_overlap_ratio_merge.sv */
// Top level of the box pair overlap ratio and merge block.
// Depends on bpo_pkg, bpo_req_if, bpo_rsp_if, bpo_geom, bpo_area, bpo_div_step.

// Each request carries a reference box and an other box (left, top, right,
// bottom, signed). Each response gives the inclusive touch flag, the share of
// the reference box covered by the intersection as unsigned
// Q1.RATIO_FRAC_BITS (truncated, 2^RATIO_FRAC_BITS means one, zero when the
// reference area is zero or negative), and the merged box. One response per
// request, in order. The block is a pipeline of RATIO_FRAC_BITS + 4 register
// stages: edge logic, two multipliers, classification, one restoring
// division step per quotient bit, and the output register. A request is
// taken every cycle while the response side does not stall. Each stage
// holds its own valid bit and loads when it is empty or its successor
// moves, so bubbles close up and requests keep coming in while a finished
// response waits to be taken. No state survives a request; reset only
// clears the valid bits.
module box_pair_overlap_ratio_merge #(
    parameter int COORD_BITS      = 16,
    parameter int RATIO_FRAC_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bpo_req_if.sink    i_req,
    bpo_rsp_if.source  o_rsp
);
    import bpo_pkg::*;

    localparam int AW     = 2 * COORD_BITS;
    localparam int FW     = RATIO_FRAC_BITS;
    localparam int NS     = FW + 4;       // total register stages
    localparam int S_MUL  = 1;
    localparam int S_CLS  = 2;
    localparam int S_DIV0 = 3;
    localparam int S_OUT  = NS - 1;

    // per-stage valid and flow control
    logic [NS-1:0] r_v;
    logic [NS-1:0] w_rdy;
    logic [NS-1:0] w_prev_v;

    assign w_rdy[S_OUT]    = ~r_v[S_OUT] | o_rsp.ready;
    assign w_prev_v[0]     = i_req.valid;

    genvar k;
    generate
        for (k = 0; k < NS - 1; k++) begin : g_flow
            assign w_rdy[k]        = ~r_v[k] | w_rdy[k+1];
            assign w_prev_v[k+1]   = r_v[k];
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int s = 0; s < NS; s++) begin
                if (w_rdy[s]) begin
                    r_v[s] <= w_prev_v[s];
                end
            end
        end
    end

    assign i_req.ready = w_rdy[0];

    // stage 0: edges
    logic                         w_g_touch;
    logic signed [COORD_BITS-1:0] w_g_ul, w_g_ut, w_g_ur, w_g_ub;
    logic [COORD_BITS-1:0]        w_g_w, w_g_h;
    logic signed [COORD_BITS:0]   w_g_dx, w_g_dy;

    bpo_geom #(.COORD_BITS(COORD_BITS)) u_geom (
        .i_clk   (i_clk),
        .i_en    (w_rdy[0]),
        .i_rl    (i_req.ref_left),
        .i_rt    (i_req.ref_top),
        .i_rr    (i_req.ref_right),
        .i_rb    (i_req.ref_bottom),
        .i_ol    (i_req.oth_left),
        .i_ot    (i_req.oth_top),
        .i_or    (i_req.oth_right),
        .i_ob    (i_req.oth_bottom),
        .o_touch (w_g_touch),
        .o_ul    (w_g_ul),
        .o_ut    (w_g_ut),
        .o_ur    (w_g_ur),
        .o_ub    (w_g_ub),
        .o_w     (w_g_w),
        .o_h     (w_g_h),
        .o_dx    (w_g_dx),
        .o_dy    (w_g_dy)
    );

    // stages 1 and 2: areas and classification
    logic [AW-1:0] w_rem [0:FW];
    logic [AW-1:0] w_den [0:FW];
    logic [FW-1:0] w_quo [0:FW];
    t_ratio_sel    w_a_sel;

    bpo_area #(.COORD_BITS(COORD_BITS)) u_area (
        .i_clk    (i_clk),
        .i_en_mul (w_rdy[S_MUL]),
        .i_en_cls (w_rdy[S_CLS]),
        .i_w      (w_g_w),
        .i_h      (w_g_h),
        .i_dx     (w_g_dx),
        .i_dy     (w_g_dy),
        .o_rem    (w_rem[0]),
        .o_den    (w_den[0]),
        .o_sel    (w_a_sel)
    );

    assign w_quo[0] = '0;

    // divider chain, one quotient bit per stage
    generate
        for (k = 0; k < FW; k++) begin : g_div
            bpo_div_step #(.AREA_BITS(AW), .QUO_BITS(FW)) u_step (
                .i_clk (i_clk),
                .i_en  (w_rdy[S_DIV0+k]),
                .i_rem (w_rem[k]),
                .i_den (w_den[k]),
                .i_quo (w_quo[k]),
                .o_rem (w_rem[k+1]),
                .o_den (w_den[k+1]),
                .o_quo (w_quo[k+1])
            );
        end
    endgenerate

    // side data riding along with the arithmetic
    logic                         r_touch [S_MUL:S_OUT];
    logic signed [COORD_BITS-1:0] r_ul    [S_MUL:S_OUT];
    logic signed [COORD_BITS-1:0] r_ut    [S_MUL:S_OUT];
    logic signed [COORD_BITS-1:0] r_ur    [S_MUL:S_OUT];
    logic signed [COORD_BITS-1:0] r_ub    [S_MUL:S_OUT];
    t_ratio_sel                   r_sel   [S_DIV0:S_OUT-1];

    generate
        for (k = S_MUL; k <= S_OUT; k++) begin : g_side
            if (k == S_MUL) begin : g_first
                always_ff @(posedge i_clk) begin
                    if (w_rdy[k]) begin
                        r_touch[k] <= w_g_touch;
                        r_ul[k]    <= w_g_ul;
                        r_ut[k]    <= w_g_ut;
                        r_ur[k]    <= w_g_ur;
                        r_ub[k]    <= w_g_ub;
                    end
                end
            end else begin : g_next
                always_ff @(posedge i_clk) begin
                    if (w_rdy[k]) begin
                        r_touch[k] <= r_touch[k-1];
                        r_ul[k]    <= r_ul[k-1];
                        r_ut[k]    <= r_ut[k-1];
                        r_ur[k]    <= r_ur[k-1];
                        r_ub[k]    <= r_ub[k-1];
                    end
                end
            end
        end

        for (k = S_DIV0; k < S_OUT; k++) begin : g_sel
            if (k == S_DIV0) begin : g_first
                always_ff @(posedge i_clk) begin
                    if (w_rdy[k]) begin
                        r_sel[k] <= w_a_sel;
                    end
                end
            end else begin : g_next
                always_ff @(posedge i_clk) begin
                    if (w_rdy[k]) begin
                        r_sel[k] <= r_sel[k-1];
                    end
                end
            end
        end
    endgenerate

    // output stage: pick the ratio
    logic [FW:0] r_ratio;
    logic [FW:0] n_ratio;

    always_comb begin
        case (r_sel[S_OUT-1])
            RSEL_ZERO: n_ratio = '0;
            RSEL_ONE:  n_ratio = {1'b1, {FW{1'b0}}};
            RSEL_DIV:  n_ratio = {1'b0, w_quo[FW]};
            default:   n_ratio = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[S_OUT]) begin
            r_ratio <= n_ratio;
        end
    end

    assign o_rsp.valid         = r_v[S_OUT];
    assign o_rsp.boxes_touch   = r_touch[S_OUT];
    assign o_rsp.overlap_ratio = r_ratio;
    assign o_rsp.union_left    = r_ul[S_OUT];
    assign o_rsp.union_top     = r_ut[S_OUT];
    assign o_rsp.union_right   = r_ur[S_OUT];
    assign o_rsp.union_bottom  = r_ub[S_OUT];
endmodule

/* dv/box_pair_overlap_ratio_merge_tb.sv */
// Self-checking testbench for box_pair_overlap_ratio_merge: directed box pairs, then random
// pairs under several idle/stall mixes, checked field by field against an in-bench predictor.
// Depends on bpo_pkg, bpo_req_if, bpo_rsp_if and the block's RTL.
`timescale 1ns / 1ps

module box_pair_overlap_ratio_merge_tb;

    localparam int CB             = 16;
    localparam int RF             = 16;
    localparam int PIPE_LATENCY   = RF + 4;        // per the block's header
    localparam logic [RF:0] RATIO_ONE = {1'b1, {RF{1'b0}}};   // Q1.16 one
    localparam int NUM_DIRECTED   = 22;
    localparam int PAIRS_PER_PHASE = 106;          // five random phases
    localparam int PRESSURE_HOLD  = 80;            // well past the pipe depth
    localparam int TIMEOUT_NS     = 200000;

    // one request: reference box, then other box
    typedef struct packed {
        logic [CB-1:0] ref_left;
        logic [CB-1:0] ref_top;
        logic [CB-1:0] ref_right;
        logic [CB-1:0] ref_bottom;
        logic [CB-1:0] oth_left;
        logic [CB-1:0] oth_top;
        logic [CB-1:0] oth_right;
        logic [CB-1:0] oth_bottom;
    } t_box_pair;

    // one response
    typedef struct packed {
        logic          boxes_touch;
        logic [RF:0]   overlap_ratio;
        logic [CB-1:0] union_left;
        logic [CB-1:0] union_top;
        logic [CB-1:0] union_right;
        logic [CB-1:0] union_bottom;
    } t_overlap_result;

    // directed row: when hand_checked is set, want is the typed-in answer,
    // otherwise the predictor supplies it
    typedef struct packed {
        t_box_pair       pair;
        logic            hand_checked;
        t_overlap_result want;
    } t_pair_row;

    typedef enum int {
        PH_STREAM,        // no idling either side
        PH_BACKPRESSURE,  // long receiver hold-off while requests keep coming
        PH_SEND_GAPS,     // sender gap chance 53 percent
        PH_RECV_STALLS,   // receiver stall chance 53 percent
        PH_BOTH_IDLE      // both at 24 of 100
    } t_traffic_phase;

    logic clk;
    logic rst_n;

    bpo_req_if #(.COORD_BITS(CB))                       req_if ();
    bpo_rsp_if #(.COORD_BITS(CB), .RATIO_FRAC_BITS(RF)) rsp_if ();

    box_pair_overlap_ratio_merge #(
        .COORD_BITS      (CB),
        .RATIO_FRAC_BITS (RF)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    t_overlap_result pending_overlap [$];   // answers owed by the block, oldest first
    t_overlap_result got_want;
    int              errors;
    int              send_gap_pct;          // used by the sender only
    int              stall_pct;             // read by the receiver, written with <=
    logic            hold_req;              // asks the receiver for one long hold-off

    // Directed requests. Typed answers only where they are obvious by eye.
    t_pair_row directed_rows [NUM_DIRECTED] = '{
        // identical boxes: full cover
        '{'{0, 0, 10, 10, 0, 0, 10, 10}, 1'b1, '{1'b1, RATIO_ONE, 0, 0, 10, 10}},
        // disjoint
        '{'{0, 0, 10, 10, 20, 20, 30, 30}, 1'b1, '{1'b0, 0, 0, 0, 30, 30}},
        // shared vertical edge: touch, zero-width intersection
        '{'{0, 0, 10, 10, 10, 0, 20, 10}, 1'b1, '{1'b1, 0, 0, 0, 20, 10}},
        // corner contact only
        '{'{0, 0, 10, 10, 10, 10, 20, 20}, 1'b1, '{1'b1, 0, 0, 0, 20, 20}},
        // one pixel gap in y: no touch
        '{'{0, 0, 10, 10, 0, 11, 10, 20}, 1'b1, '{1'b0, 0, 0, 0, 10, 20}},
        // zero-width reference: area zero gives ratio zero
        '{'{5, 5, 5, 20, 0, 0, 10, 10}, 1'b1, '{1'b1, 0, 0, 0, 10, 20}},
        // reference inverted in x: negative area
        '{'{10, 0, 0, 10, 0, 0, 10, 10}, 1'b1, '{1'b1, 0, 0, 0, 10, 10}},
        // reference inverted in both axes: positive area, empty intersection
        '{'{10, 10, 0, 0, 0, 0, 10, 10}, 1'b1, '{1'b1, 0, 0, 0, 10, 10}},
        // half cover
        '{'{0, 0, 10, 10, 5, 0, 15, 10}, 1'b1, '{1'b1, 32768, 0, 0, 15, 10}},
        // quarter cover
        '{'{0, 0, 2, 2, 1, 1, 3, 3}, 1'b1, '{1'b1, 16384, 0, 0, 3, 3}},
        // reference inside other: saturates
        '{'{2, 2, 4, 4, 0, 0, 10, 10}, 1'b1, '{1'b1, RATIO_ONE, 0, 0, 10, 10}},
        // full coordinate range, both boxes
        '{'{-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767}, 1'b1,
          '{1'b1, RATIO_ONE, -32768, -32768, 32767, 32767}},
        // full-range reference, unit other: ratio truncates to zero
        '{'{-32768, -32768, 32767, 32767, 0, 0, 1, 1}, 1'b1,
          '{1'b1, 0, -32768, -32768, 32767, 32767}},
        // unit reference, full-range other
        '{'{0, 0, 1, 1, -32768, -32768, 32767, 32767}, 1'b1,
          '{1'b1, RATIO_ONE, -32768, -32768, 32767, 32767}},
        // opposite extreme corners
        '{'{-32768, -32768, -32767, -32767, 32766, 32766, 32767, 32767}, 1'b1,
          '{1'b0, 0, -32768, -32768, 32767, 32767}},
        // all ones
        '{'{-1, -1, -1, -1, -1, -1, -1, -1}, 1'b1, '{1'b1, 0, -1, -1, -1, -1}},
        // rest go through the predictor
        '{'{0, 0, 3, 1, 0, 0, 1, 1}, 1'b0, '0},                     // one third
        '{'{0, 0, 32767, 32767, 0, 0, 32767, 32766}, 1'b0, '0},     // just under one
        '{'{-32768, 0, 32767, 1, -100, -5, 100, 5}, 1'b0, '0},      // thin wide ref
        '{'{0, 0, 10, 10, 8, 8, 2, 2}, 1'b0, '0},                   // inverted other
        '{'{32767, 32767, -32768, -32768, 0, 0, 0, 0}, 1'b0, '0},   // huge inverted ref
        '{'{-7, -3, 9, 12, -2, -10, 4, 6}, 1'b0, '0}                // partial overlap
    };

    // ---------------------------------------------------------------------
    // Predictor: touch flag, Q1.16 cover ratio of the reference box, merged box
    // ---------------------------------------------------------------------
    function automatic t_overlap_result calc_overlap(input t_box_pair p);
        longint          rl, rt, rr, rb, ol, ot, orr, ob;
        longint          span_x, span_y, cover_area, ref_area;
        t_overlap_result r;
        rl  = $signed(p.ref_left);
        rt  = $signed(p.ref_top);
        rr  = $signed(p.ref_right);
        rb  = $signed(p.ref_bottom);
        ol  = $signed(p.oth_left);
        ot  = $signed(p.oth_top);
        orr = $signed(p.oth_right);
        ob  = $signed(p.oth_bottom);

        // edges count as contact
        r.boxes_touch = (rr >= ol) && (rl <= orr) && (rb >= ot) && (rt <= ob);

        // intersection extents, clamped at zero per axis
        span_x = ((rr < orr) ? rr : orr) - ((rl > ol) ? rl : ol);
        span_y = ((rb < ob) ? rb : ob) - ((rt > ot) ? rt : ot);
        if (span_x < 0) span_x = 0;
        if (span_y < 0) span_y = 0;
        cover_area = span_x * span_y;
        // signed: inverted in both axes comes out positive
        ref_area = (rr - rl) * (rb - rt);

        if (ref_area <= 0) begin
            r.overlap_ratio = '0;
        end else if (cover_area >= ref_area) begin
            r.overlap_ratio = RATIO_ONE;
        end else begin
            // cover_area < 2^32, so the shifted numerator fits in 64 bits
            r.overlap_ratio = (RF+1)'((cover_area << RF) / ref_area);
        end

        r.union_left   = (rl < ol)  ? p.ref_left   : p.oth_left;
        r.union_top    = (rt < ot)  ? p.ref_top    : p.oth_top;
        r.union_right  = (rr > orr) ? p.ref_right  : p.oth_right;
        r.union_bottom = (rb > ob)  ? p.ref_bottom : p.oth_bottom;
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // Random box pairs. Mostly well-formed boxes close enough to overlap,
    // plus raw noise, huge boxes, extreme corners and inverted boxes.
    // ---------------------------------------------------------------------
    function automatic t_box_pair random_pair();
        int        corner_vals [8] = '{-32768, -32767, -2, -1, 0, 1, 32766, 32767};
        int        rl, rt, rr, rb, ol, ot, orr, ob, swap_tmp, base_x, base_y;
        t_box_pair p;
        base_x = $urandom_range(0, 60000) - 30000;
        base_y = $urandom_range(0, 60000) - 30000;
        rl  = base_x;
        rt  = base_y;
        rr  = rl + $urandom_range(0, 48);
        rb  = rt + $urandom_range(0, 48);
        ol  = base_x + $urandom_range(0, 64) - 32;
        ot  = base_y + $urandom_range(0, 64) - 32;
        orr = ol + $urandom_range(0, 48);
        ob  = ot + $urandom_range(0, 48);
        case ($urandom_range(0, 9))
            0, 1: begin
                // raw noise: every bit of every field toggles
                rl  = $urandom_range(0, 65535);
                rt  = $urandom_range(0, 65535);
                rr  = $urandom_range(0, 65535);
                rb  = $urandom_range(0, 65535);
                ol  = $urandom_range(0, 65535);
                ot  = $urandom_range(0, 65535);
                orr = $urandom_range(0, 65535);
                ob  = $urandom_range(0, 65535);
            end
            6: begin
                // other nested inside the reference
                ol  = rl + $urandom_range(0, rr - rl);
                ot  = rt + $urandom_range(0, rb - rt);
                orr = ol + $urandom_range(0, rr - ol);
                ob  = ot + $urandom_range(0, rb - ot);
            end
            7: begin
                // large boxes straddling the origin
                rl  = -$urandom_range(0, 32768);
                rt  = -$urandom_range(0, 32768);
                rr  = $urandom_range(0, 32767);
                rb  = $urandom_range(0, 32767);
                ol  = -$urandom_range(0, 32768);
                ot  = -$urandom_range(0, 32768);
                orr = $urandom_range(0, 32767);
                ob  = $urandom_range(0, 32767);
            end
            8: begin
                rl  = corner_vals[$urandom_range(0, 7)];
                rt  = corner_vals[$urandom_range(0, 7)];
                rr  = corner_vals[$urandom_range(0, 7)];
                rb  = corner_vals[$urandom_range(0, 7)];
                ol  = corner_vals[$urandom_range(0, 7)];
                ot  = corner_vals[$urandom_range(0, 7)];
                orr = corner_vals[$urandom_range(0, 7)];
                ob  = corner_vals[$urandom_range(0, 7)];
            end
            9: begin
                // malformed: flip some axes of either box
                if ($urandom_range(0, 1)) begin swap_tmp = rl; rl = rr; rr = swap_tmp; end
                if ($urandom_range(0, 1)) begin swap_tmp = rt; rt = rb; rb = swap_tmp; end
                if ($urandom_range(0, 1)) begin swap_tmp = ol; ol = orr; orr = swap_tmp; end
                if ($urandom_range(0, 1)) begin swap_tmp = ot; ot = ob; ob = swap_tmp; end
            end
            default: ;  // small well-formed pair as set up above
        endcase
        p.ref_left   = CB'(rl);
        p.ref_top    = CB'(rt);
        p.ref_right  = CB'(rr);
        p.ref_bottom = CB'(rb);
        p.oth_left   = CB'(ol);
        p.oth_top    = CB'(ot);
        p.oth_right  = CB'(orr);
        p.oth_bottom = CB'(ob);
        return p;
    endfunction

    // Offer one request, with random idle cycles ahead of it, and book the
    // answer once it is taken. valid is left high on return so back-to-back
    // requests never drop it.
    task automatic send_pair(input t_box_pair p, input t_overlap_result want);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid      <= 1'b1;
        req_if.ref_left   <= p.ref_left;
        req_if.ref_top    <= p.ref_top;
        req_if.ref_right  <= p.ref_right;
        req_if.ref_bottom <= p.ref_bottom;
        req_if.oth_left   <= p.oth_left;
        req_if.oth_top    <= p.oth_top;
        req_if.oth_right  <= p.oth_right;
        req_if.oth_bottom <= p.oth_bottom;
        do @(posedge clk); while (!req_if.ready);
        pending_overlap.push_back(want);
    endtask

    task automatic compare_field(input string name, input logic signed [31:0] want_v,
                                 input logic signed [31:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
            errors++;
        end
    endtask

    // clock, 2 ns period
    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // hard stop if the block hangs or loses a response
    initial begin
        #TIMEOUT_NS;
        $display("Some tests failed");
        $finish;
    end

    // Receiver: random stalls at stall_pct, plus one long hold-off on request
    // so the pipe fills and the block pushes back on its input.
    initial begin : rsp_ready_gen
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req && !hold_done) begin
                hold_left = PRESSURE_HOLD;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                rsp_if.ready <= 1'b0;
                hold_left--;
            end else begin
                rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // Response checker: every accepted response against the oldest booking.
    always @(posedge clk) begin
        if (rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_overlap.size() == 0) begin
                $display("%0t: response with nothing pending, expected none, got ratio %0d",
                         $time, rsp_if.overlap_ratio);
                errors++;
            end else begin
                got_want = pending_overlap.pop_front();
                compare_field("boxes_touch", 32'(got_want.boxes_touch),
                              32'(rsp_if.boxes_touch));
                compare_field("overlap_ratio", 32'(got_want.overlap_ratio),
                              32'(rsp_if.overlap_ratio));
                compare_field("union_left", 32'($signed(got_want.union_left)),
                              32'(rsp_if.union_left));
                compare_field("union_top", 32'($signed(got_want.union_top)),
                              32'(rsp_if.union_top));
                compare_field("union_right", 32'($signed(got_want.union_right)),
                              32'(rsp_if.union_right));
                compare_field("union_bottom", 32'($signed(got_want.union_bottom)),
                              32'(rsp_if.union_bottom));
            end
        end
    end

    // Main sequence: reset, directed table, random phases, drain, verdict.
    initial begin : stimulus
        t_box_pair      pair;
        t_traffic_phase phase;
        errors       = 0;
        send_gap_pct = 0;
        stall_pct    <= 0;
        hold_req     <= 1'b0;
        rst_n        <= 1'b0;
        req_if.valid      <= 1'b0;
        req_if.ref_left   <= '0;
        req_if.ref_top    <= '0;
        req_if.ref_right  <= '0;
        req_if.ref_bottom <= '0;
        req_if.oth_left   <= '0;
        req_if.oth_top    <= '0;
        req_if.oth_right  <= '0;
        req_if.oth_bottom <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, back to back
        for (int i = 0; i < NUM_DIRECTED; i++) begin
            send_pair(directed_rows[i].pair,
                      directed_rows[i].hand_checked ? directed_rows[i].want
                                                    : calc_overlap(directed_rows[i].pair));
        end

        // random traffic, one idle mix per phase
        for (int ph = 0; ph <= int'(PH_BOTH_IDLE); ph++) begin
            phase = t_traffic_phase'(ph);
            case (phase)
                PH_STREAM: begin
                    send_gap_pct = 0;
                    stall_pct   <= 0;
                end
                PH_BACKPRESSURE: begin
                    send_gap_pct = 0;
                    stall_pct   <= 0;
                    hold_req    <= 1'b1;
                end
                PH_SEND_GAPS: begin
                    send_gap_pct = 53;
                    stall_pct   <= 0;
                end
                PH_RECV_STALLS: begin
                    send_gap_pct = 0;
                    stall_pct   <= 53;
                end
                default: begin
                    send_gap_pct = 24;
                    stall_pct   <= 24;
                end
            endcase
            repeat (PAIRS_PER_PHASE) begin
                pair = random_pair();
                send_pair(pair, calc_overlap(pair));
            end
        end
        req_if.valid <= 1'b0;

        // drain, then watch a little longer for strays
        while (pending_overlap.size() != 0) @(posedge clk);
        repeat (2 * PIPE_LATENCY) @(posedge clk);

        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
